// ===== design/wildcard_byte_pattern_scan_defines.svh =====
// Assertion macros for the wildcard byte pattern scanner.
// Used by modules that check their own control logic; needs clk and rst in scope.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH
`ifndef SYNTHESIS
`define WBPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wbps: same-cycle check failed");
`define WBPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wbps: next-cycle check failed");
`else
`define WBPS_ASSERT_IMP(lbl, ante, cons)
`define WBPS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/wbps_pkg.sv =====
// Shared constants, types and register codes of the wildcard byte pattern scanner.
// No dependencies; imported by every module of the block.
package wbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int OFFSET_BITS = 32;

  localparam int BYTE_W      = 8;
  localparam int PAT_BYTES   = 16;
  localparam int LEN_W       = 5;
  localparam int SEEN_W      = 33;
  localparam int ADDR_W      = 48;
  localparam int OFF_FIELD_W = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int STATUS_W    = 2;
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam int OUT_RAW_W   = STATUS_W + OFF_FIELD_W + ADDR_W;
  localparam int OUT_W       = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_W - OUT_RAW_W;

  // Offset wraps to OFFSET_BITS before it is added to the base
  localparam logic [ADDR_W-1:0] OFF_MASK =
    (OFFSET_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
    ((ADDR_W'(1) << OFFSET_BITS) - ADDR_W'(1));

  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD       = 2'd2
  } status_t;

  typedef struct packed {
    logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
    logic [PAT_BYTES-1:0]             care;
    logic [LEN_W-1:0]                 length;
    logic [ADDR_W-1:0]                base;
  } cfg_t;

  // Window stage contents handed to the compare stage
  typedef struct packed {
    logic                               valid;
    logic                               last;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] bytes;
    logic [SEEN_W-1:0]                  count;
  } win_t;

endpackage

// ===== design/wbps_cfg_regs.sv =====
// Configuration register file of the wildcard byte pattern scanner.
// Depends on wbps_pkg for register codes and the cfg_t bundle.
module wbps_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data,
  output wbps_pkg::cfg_t                    cfg
);
  import wbps_pkg::*;

  // Writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // Store a beat into the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PAT_LOW:  cfg.pattern[7:0]  <= cfg_data;
        REG_PAT_HIGH: cfg.pattern[15:8] <= cfg_data;
        REG_CARE:     cfg.care          <= cfg_data[PAT_BYTES-1:0];
        REG_LENGTH:   cfg.length        <= cfg_data[LEN_W-1:0];
        REG_BASE:     cfg.base          <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/wbps_window.sv =====
// Input stage: shifts each accepted byte into the window and counts region bytes.
// Depends on wbps_pkg for the win_t bundle and widths.
module wbps_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wbps_pkg::BYTE_W-1:0] in_byte,
  input  logic                        in_last,
  input  logic                        take,
  output wbps_pkg::win_t              win
);
  import wbps_pkg::*;

  logic                               start;
  logic                               accept;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] bytes_next;
  logic [SEEN_W-1:0]                  count_next;

  // Take a new beat when the stage is empty or drains this cycle
  assign in_ready = !win.valid || take;
  assign accept   = in_valid && in_ready;

  // Shift the window; a new region starts from an empty window
  always_comb begin
    bytes_next[0] = in_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      bytes_next[k] = start ? '0 : win.bytes[k-1];
    end
    if (start) begin
      count_next = SEEN_W'(1);
    end else if (win.count == SEEN_MAX) begin
      count_next = win.count;
    end else begin
      count_next = win.count + SEEN_W'(1);
    end
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      win.valid <= 1'b0;
      start     <= 1'b1;
    end else if (accept) begin
      win.valid <= 1'b1;
      start     <= in_last;
    end else if (take) begin
      win.valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      win.bytes <= bytes_next;
      win.count <= count_next;
      win.last  <= in_last;
    end
  end

endmodule

// ===== design/wbps_match.sv =====
// Compare stage and result register: masked compare of the window against the
// pattern, first-result tracking, offset and address. Depends on wbps_pkg.
`include "wildcard_byte_pattern_scan_defines.svh"
module wbps_match (
  input  logic                              clk,
  input  logic                              rst,
  input  wbps_pkg::cfg_t                    cfg,
  input  wbps_pkg::win_t                    win,
  output logic                              take,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wbps_pkg::status_t                 out_status,
  output logic [wbps_pkg::OFF_FIELD_W-1:0]  out_offset,
  output logic [wbps_pkg::ADDR_W-1:0]       out_address
);
  import wbps_pkg::*;

  logic                   given;
  logic [LEN_W-1:0]       len_used;
  logic [PAT_BYTES-1:0]   used;
  logic                   bad;
  logic                   hit;
  logic                   eligible;
  logic                   found;
  logic                   bad_hit;
  logic                   emit;
  logic [LEN_W-1:0]       sel;
  logic [SEEN_W-1:0]      diff;
  logic [ADDR_W-1:0]      off_full;
  status_t                status_next;

  // Drain the window stage when the result register is free
  assign take = win.valid && (!out_valid || out_ready);

  // Clamp the length and build the in-use mask
  always_comb begin
    if (cfg.length > LEN_W'(MAX_PATTERN)) begin
      len_used = LEN_W'(MAX_PATTERN);
    end else begin
      len_used = cfg.length;
    end
    for (int i = 0; i < PAT_BYTES; i++) begin
      used[i] = LEN_W'(i) < len_used;
    end
  end

  assign bad = (cfg.care & used) == '0;

  // Masked compare: pattern byte i sits len-1-i places back in the window
  always_comb begin
    hit = 1'b1;
    sel = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      sel = len_used - LEN_W'(1) - LEN_W'(i);
      if (used[i] && cfg.care[i] && (win.bytes[sel[IDX_W-1:0]] != cfg.pattern[i])) begin
        hit = 1'b0;
      end
    end
  end

  assign eligible = !given && (len_used != '0) && (win.count >= SEEN_W'(len_used));
  assign found    = eligible && !bad && hit;
  assign bad_hit  = eligible && bad;
  assign emit     = found || bad_hit || (win.last && !given);

  // Match start offset, wrapped to the offset width
  assign diff     = win.count - SEEN_W'(len_used);
  assign off_full = ADDR_W'(diff) & OFF_MASK;

  always_comb begin
    priority if (found) begin
      status_next = ST_FOUND;
    end else if (bad_hit) begin
      status_next = ST_BAD;
    end else begin
      status_next = ST_NOT_FOUND;
    end
  end

  // Track whether this region already reported
  always_ff @(posedge clk) begin
    if (rst) begin
      given <= 1'b0;
    end else if (take) begin
      if (win.last) begin
        given <= 1'b0;
      end else if (found || bad_hit) begin
        given <= 1'b1;
      end
    end
  end

  // Result register: load on emit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_status <= status_next;
      if (found) begin
        out_offset  <= OFF_FIELD_W'(off_full);
        out_address <= cfg.base + off_full;
      end else begin
        out_offset  <= '0;
        out_address <= '0;
      end
    end
  end

  `WBPS_ASSERT_IMP(a_zero_unless_found,
    out_valid && (out_status != ST_FOUND), (out_offset == '0) && (out_address == '0))
  `WBPS_ASSERT_NXT(a_region_end_clears, take && win.last, !given)
  `WBPS_ASSERT_NXT(a_result_marks_region,
    take && (found || bad_hit) && !win.last, given && out_valid)

endmodule

// ===== design/wildcard_byte_pattern_scan.sv =====
// Top level of the wildcard byte pattern scanner.
// Depends on wbps_pkg, wbps_cfg_regs, wbps_window and wbps_match.
//
// Usage:
//   Region bytes arrive on the s_axis channel, one per beat, with s_axis_tlast
//   on the final byte of the region. The cfg channel writes the pattern bytes,
//   care mask, pattern length and region base (index 0..4); write it only
//   while no beat is in flight.
//   At most one result leaves on m_axis per region: found with offset and
//   address at the first full match, bad pattern for an all-wildcard pattern,
//   or not found on the last byte. Bytes after a result are absorbed silently.
//   Throughput: one byte per cycle while m_axis is not stalled, set by the
//   combinational masked compare of the whole window against the pattern.
//   A byte accepted into the window stage puts its result on m_axis once it
//   moves on to the result stage (two register stages: window, result).
//   When m_axis stalls, the result register holds and the window stage fills;
//   s_axis_tready then drops until the result is taken.
//   Reset clears the configuration to zero, empties both stages and starts a
//   new region; no clearing pass is needed.
module wildcard_byte_pattern_scan (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [wbps_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] data_byte
  input  logic                              s_axis_tlast,  // last_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] scan_status, [33:2] match_offset, [81:34] match_address, rest zero
  output logic [wbps_pkg::OUT_W-1:0]        m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wbps_pkg::*;

  cfg_t                    cfg;
  win_t                    win;
  logic                    take;
  status_t                 out_status;
  logic [OFF_FIELD_W-1:0]  out_offset;
  logic [ADDR_W-1:0]       out_address;

  wbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wbps_window u_window (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .take     (take),
    .win      (win)
  );

  wbps_match u_match (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .win         (win),
    .take        (take),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_status  (out_status),
    .out_offset  (out_offset),
    .out_address (out_address)
  );

  // Pack the result beat, first field lowest
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_address, out_offset, out_status};

endmodule
